FILE: rtl/csvft_pkg.sv
// ----------------------------------------------------------------------------
// csvft_pkg
// Types and constants shared by the delimited-text tokenizer and its checker.
// ----------------------------------------------------------------------------
package csvft_pkg;

    localparam int DEFAULT_MAX_COLUMNS = 256;
    localparam int DEFAULT_MAX_ROWS    = 65536;

    localparam int COLUMN_INDEX_W = 9;
    localparam int ROW_COUNT_W    = 17;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam logic [7:0] DELIMITER_RESET = 8'h2C;
    localparam logic [7:0] ENCLOSURE_RESET = 8'h22;

    // Register indexes, as decoded from paddr[2]
    localparam logic REG_DELIMITER = 1'b0;
    localparam logic REG_ENCLOSURE = 1'b1;

    typedef enum logic [2:0] {
        KIND_DATA       = 3'd0,
        KIND_FIELD_END  = 3'd1,
        KIND_RECORD_END = 3'd2,
        KIND_MISMATCH   = 3'd3,
        KIND_DONE       = 3'd4
    } kind_t;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_END  = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } req_item_t;

    typedef struct packed {
        kind_t                     kind;
        logic [7:0]                out_byte;
        logic [COLUMN_INDEX_W-1:0] column_index;
        logic [ROW_COUNT_W-1:0]    row_count;
        logic                      success;
    } rsp_item_t;

endpackage

FILE: rtl/csv_field_tokenizer.sv
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// Streaming tokenizer for delimited text with quoted fields, one byte a cycle while rsp is not stalled.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                          Moves
//  req       in         req_valid, req_ready, req_data   text byte or end of text
//  rsp       out        rsp_valid, rsp_ready, rsp_data   token, record end, status
//  apb       in/out     psel, penable, pwrite, paddr,    delimiter and enclosure
//                       pwdata, prdata, pready
//
// One transfer is taken per cycle while req_ready is high. An accepted item is
// held in an input register, then decoded against the parser state and its
// result (if any) written to the output register, from which it is presented
// on rsp. Stalls on rsp hold the input register and then deassert req_ready.
// Reset clears the parser state and loads comma and double quote.
// ----------------------------------------------------------------------------
module csv_field_tokenizer #(
    parameter int MAX_COLUMNS = csvft_pkg::DEFAULT_MAX_COLUMNS,
    parameter int MAX_ROWS    = csvft_pkg::DEFAULT_MAX_ROWS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  csvft_pkg::req_item_t                req_data,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output csvft_pkg::rsp_item_t                rsp_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [csvft_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [csvft_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [csvft_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import csvft_pkg::*;

    localparam int COL_W = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_COLUMNS);
    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(MAX_ROWS);

    // Configuration
    logic [7:0] delimiter_reg;
    logic [7:0] enclosure_reg;
    logic       cfg_write;

    // Pipeline
    logic      s1_valid_reg, s1_valid_next;
    req_item_t s1_item_reg;
    logic      rsp_valid_reg, rsp_valid_next;
    rsp_item_t rsp_item_reg;
    logic      advance;
    logic      process;

    // Parser state
    logic             quoting_reg, quoting_next;
    logic             pending_reg, pending_next;
    logic             swallow_reg, swallow_next;
    logic [COL_W-1:0] fields_reg, fields_next;
    logic [COL_W-1:0] expected_reg, expected_next;
    logic [ROW_W-1:0] rows_reg, rows_next;
    logic             mismatch_reg, mismatch_next;
    logic             seen_reg, seen_next;

    // Decode results
    logic                      res_valid;
    kind_t                     res_kind;
    logic [7:0]                res_byte;
    logic [COL_W-1:0]          res_col;
    logic [ROW_W-1:0]          res_rows;
    logic                      res_success;
    logic [COL_W-1:0]          count;
    logic                      eff_quoting;
    logic [7:0]                c;
    logic [COL_W+COLUMN_INDEX_W-1:0] col_ext;
    logic [ROW_W+ROW_COUNT_W-1:0]    row_ext;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = {{(APB_DATA_W-8){1'b0}},
                        (paddr[2] == REG_ENCLOSURE) ? enclosure_reg : delimiter_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg <= DELIMITER_RESET;
            enclosure_reg <= ENCLOSURE_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_ENCLOSURE)
            begin
                enclosure_reg <= pwdata[7:0];
            end
            else
            begin
                delimiter_reg <= pwdata[7:0];
            end
        end
    end

    assign advance   = !rsp_valid_reg || rsp_ready;
    assign process   = s1_valid_reg && advance;
    assign req_ready = !s1_valid_reg || advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_valid && req_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (process)
        begin
            s1_valid_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (process)
        begin
            rsp_valid_next = res_valid;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Per-byte decode against the parser state
    always_comb
    begin
        quoting_next  = quoting_reg;
        pending_next  = pending_reg;
        swallow_next  = swallow_reg;
        fields_next   = fields_reg;
        expected_next = expected_reg;
        rows_next     = rows_reg;
        mismatch_next = mismatch_reg;
        seen_next     = seen_reg;
        res_valid     = 1'b0;
        res_kind      = KIND_DATA;
        res_byte      = 8'd0;
        res_col       = '0;
        res_rows      = rows_reg;
        res_success   = 1'b0;
        c             = s1_item_reg.data_byte;
        eff_quoting   = quoting_reg;
        count         = (fields_reg == COL_MAX) ? fields_reg : fields_reg + 1'b1;

        if (s1_item_reg.req_type == REQ_END)
        begin
            res_valid     = 1'b1;
            res_kind      = KIND_DONE;
            res_success   = seen_reg && !mismatch_reg;
            quoting_next  = 1'b0;
            pending_next  = 1'b0;
            swallow_next  = 1'b0;
            fields_next   = '0;
            expected_next = '0;
            rows_next     = '0;
            mismatch_next = 1'b0;
            seen_next     = 1'b0;
        end
        else
        begin
            seen_next = 1'b1;
            if (!mismatch_reg)
            begin
                swallow_next = 1'b0;
                if (!(swallow_reg && c == CHAR_LF))
                begin
                    if (pending_reg)
                    begin
                        pending_next = 1'b0;
                        if (c != enclosure_reg)
                        begin
                            eff_quoting  = 1'b0;
                            quoting_next = 1'b0;
                        end
                    end

                    if (pending_reg && c == enclosure_reg)
                    begin
                        // Doubled enclosure inside quotes: one literal enclosure
                        res_valid = 1'b1;
                        res_kind  = KIND_DATA;
                        res_byte  = c;
                        res_col   = fields_reg;
                    end
                    else if (c == enclosure_reg)
                    begin
                        if (eff_quoting)
                        begin
                            pending_next = 1'b1;
                        end
                        else
                        begin
                            quoting_next = 1'b1;
                        end
                    end
                    else if (!eff_quoting && c == delimiter_reg)
                    begin
                        res_valid = 1'b1;
                        res_kind  = KIND_FIELD_END;
                        res_col   = fields_reg;
                        if (fields_reg < COL_MAX)
                        begin
                            fields_next = fields_reg + 1'b1;
                        end
                    end
                    else if (!eff_quoting && (c == CHAR_CR || c == CHAR_LF))
                    begin
                        fields_next  = '0;
                        swallow_next = 1'b1;
                        res_valid    = 1'b1;
                        res_col      = count;
                        if (rows_reg != '0 && count != expected_reg)
                        begin
                            mismatch_next = 1'b1;
                            res_kind      = KIND_MISMATCH;
                        end
                        else
                        begin
                            if (rows_reg == '0)
                            begin
                                expected_next = count;
                            end
                            if (rows_reg < ROW_MAX)
                            begin
                                rows_next = rows_reg + 1'b1;
                            end
                            res_kind = KIND_RECORD_END;
                            res_rows = rows_next;
                        end
                    end
                    else
                    begin
                        res_valid = 1'b1;
                        res_kind  = KIND_DATA;
                        res_byte  = c;
                        res_col   = fields_reg;
                    end
                end
            end
        end

        col_ext = {{COLUMN_INDEX_W{1'b0}}, res_col};
        row_ext = {{ROW_COUNT_W{1'b0}}, res_rows};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            quoting_reg   <= 1'b0;
            pending_reg   <= 1'b0;
            swallow_reg   <= 1'b0;
            fields_reg    <= '0;
            expected_reg  <= '0;
            rows_reg      <= '0;
            mismatch_reg  <= 1'b0;
            seen_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (process)
            begin
                quoting_reg  <= quoting_next;
                pending_reg  <= pending_next;
                swallow_reg  <= swallow_next;
                fields_reg   <= fields_next;
                expected_reg <= expected_next;
                rows_reg     <= rows_next;
                mismatch_reg <= mismatch_next;
                seen_reg     <= seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_item_reg <= req_data;
        end
        if (process && res_valid)
        begin
            rsp_item_reg.kind         <= res_kind;
            rsp_item_reg.out_byte     <= res_byte;
            rsp_item_reg.column_index <= col_ext[COLUMN_INDEX_W-1:0];
            rsp_item_reg.row_count    <= row_ext[ROW_COUNT_W-1:0];
            rsp_item_reg.success      <= res_success;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_item_reg;

endmodule

FILE: rtl/csvft_checker.sv
// ----------------------------------------------------------------------------
// csvft_checker
// Port-level assertions for the tokenizer, bound to its top level.
// ----------------------------------------------------------------------------
module csvft_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_ready,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input csvft_pkg::rsp_item_t rsp_data
);
    import csvft_pkg::*;

    // A stalled result stays in place until its transfer completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result changed or vanished while stalled");

    // The input side only backs up when a result is waiting on a stalled output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("input stalled without output back-pressure");

    // Only the end-of-text status carries a success flag, and with it a zero column and byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.success |-> rsp_data.kind == KIND_DONE
            && rsp_data.column_index == '0 && rsp_data.out_byte == 8'd0)
        else $error("success flag outside end-of-text status");

    // Leaving reset, no result is presented.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !rsp_valid)
        else $error("result presented straight out of reset");

endmodule

bind csv_field_tokenizer csvft_checker u_csvft_checker (.*);

FILE: dv/csv_field_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_field_tokenizer_tb
// Feeds delimited text through the tokenizer under random handshake gaps and
// checks every token against an in-bench model of the quoting, record and
// column-count rules, across several delimiter and enclosure settings.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_tb;

    import csvft_pkg::*;

    localparam int MAX_COLS    = DEFAULT_MAX_COLUMNS;
    localparam int MAX_RECORDS = DEFAULT_MAX_ROWS;
    localparam int PHASE_ITEMS = 190;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic      req_valid = 1'b0;
    logic      req_ready;
    req_item_t req_data = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp_data;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Items waiting to be driven and tokens waiting to come out.
    req_item_t text_feed[$];
    rsp_item_t expected_tokens[$];

    logic req_taken = 1'b0;
    logic rsp_taken = 1'b0;
    logic req_calm = 1'b0;
    logic rsp_calm = 1'b0;
    int   req_gap = 0;
    int   rsp_stall = 0;

    int errors = 0;
    int items_queued = 0;
    int items_fed = 0;
    int tokens_checked = 0;
    int texts_done = 0;
    int mismatches_seen = 0;
    int settings_used = 1;

    // Tokenizer model state.
    logic [7:0]             delim_cfg = DELIMITER_RESET;
    logic [7:0]             encl_cfg = ENCLOSURE_RESET;
    logic                   in_quotes = 1'b0;
    logic                   close_pending = 1'b0;
    logic                   after_record = 1'b0;
    logic [COLUMN_INDEX_W-1:0] col_count = '0;
    logic [COLUMN_INDEX_W-1:0] row_width = '0;
    logic [ROW_COUNT_W-1:0]    rows_done = '0;
    logic                   col_error = 1'b0;
    logic                   text_started = 1'b0;

    csv_field_tokenizer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic report_error(input string what);
        errors++;
        if (errors <= 100)
            $display("ERROR at %0t ns: %s", $time, what);
    endtask

    // Works out the token, if any, that one accepted item produces.
    function automatic bit tokenize(input req_item_t it, output rsp_item_t tok);
        logic [7:0] c;
        int         width;
        c = it.data_byte;
        tok = '0;
        tok.row_count = rows_done;
        if (it.req_type == REQ_END)
        begin
            tok.kind = KIND_DONE;
            tok.success = text_started && !col_error;
            in_quotes = 1'b0;
            close_pending = 1'b0;
            after_record = 1'b0;
            col_count = '0;
            row_width = '0;
            rows_done = '0;
            col_error = 1'b0;
            text_started = 1'b0;
            return 1'b1;
        end
        text_started = 1'b1;
        if (col_error)
            return 1'b0;
        if (after_record)
        begin
            after_record = 1'b0;
            if (c == CHAR_LF)
                return 1'b0;
        end
        if (close_pending)
        begin
            close_pending = 1'b0;
            if (c == encl_cfg)
            begin
                tok.kind = KIND_DATA;
                tok.out_byte = c;
                tok.column_index = col_count;
                return 1'b1;
            end
            in_quotes = 1'b0;
        end
        if (c == encl_cfg)
        begin
            if (in_quotes)
                close_pending = 1'b1;
            else
                in_quotes = 1'b1;
            return 1'b0;
        end
        if (!in_quotes && c == delim_cfg)
        begin
            tok.kind = KIND_FIELD_END;
            tok.column_index = col_count;
            if (col_count < MAX_COLS)
                col_count++;
            return 1'b1;
        end
        if (!in_quotes && (c == CHAR_CR || c == CHAR_LF))
        begin
            width = col_count + 1;
            if (width > MAX_COLS)
                width = MAX_COLS;
            col_count = '0;
            after_record = 1'b1;
            tok.column_index = COLUMN_INDEX_W'(width);
            if (rows_done == 0)
                row_width = COLUMN_INDEX_W'(width);
            else if (width != row_width)
            begin
                col_error = 1'b1;
                tok.kind = KIND_MISMATCH;
                return 1'b1;
            end
            if (rows_done < MAX_RECORDS)
                rows_done++;
            tok.kind = KIND_RECORD_END;
            tok.row_count = rows_done;
            return 1'b1;
        end
        tok.kind = KIND_DATA;
        tok.out_byte = c;
        tok.column_index = col_count;
        return 1'b1;
    endfunction

    // Sender: presents queued items, with a drawn gap before each one.
    always @(negedge clk)
    begin
        int w;
        if ($urandom_range(0, 79) == 0)
            req_calm <= !req_calm;
        w = req_taken ? (req_calm ? 0 : int'($urandom_range(0, 12))) : req_gap;
        if (rst_n && !(req_valid && !req_taken))
        begin
            if (w > 0)
            begin
                req_valid <= 1'b0;
                req_gap <= w - 1;
            end
            else if (text_feed.size() != 0)
            begin
                req_data <= text_feed.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Receiver: after each transfer, deasserts rsp_ready for a drawn stall.
    always @(negedge clk)
    begin
        int w;
        if ($urandom_range(0, 79) == 0)
            rsp_calm <= !rsp_calm;
        w = rsp_taken ? (rsp_calm ? 0 : int'($urandom_range(0, 12))) : rsp_stall;
        if (w > 0)
        begin
            rsp_ready <= 1'b0;
            rsp_stall <= w - 1;
        end
        else
            rsp_ready <= 1'b1;
    end

    // Monitor: predicts on every input transfer, checks every output transfer.
    always @(posedge clk)
    begin
        rsp_item_t produced;
        rsp_item_t want;
        req_taken <= req_valid && req_ready;
        rsp_taken <= rsp_valid && rsp_ready;
        if (req_valid && req_ready)
        begin
            items_fed++;
            if (tokenize(req_data, produced))
                expected_tokens.insert(expected_tokens.size(), produced);
        end
        if (rsp_valid && rsp_ready)
        begin
            tokens_checked++;
            if (rsp_data.kind == KIND_DONE)
                texts_done++;
            if (rsp_data.kind == KIND_MISMATCH)
                mismatches_seen++;
            if (expected_tokens.size() == 0)
                report_error($sformatf("token kind %0d arrived with nothing expected",
                                       rsp_data.kind));
            else
            begin
                want = expected_tokens.pop_front();
                if (rsp_data.kind !== want.kind)
                    report_error($sformatf("kind %0d, expected %0d",
                                           rsp_data.kind, want.kind));
                if (rsp_data.out_byte !== want.out_byte)
                    report_error($sformatf("out_byte %h, expected %h",
                                           rsp_data.out_byte, want.out_byte));
                if (rsp_data.column_index !== want.column_index)
                    report_error($sformatf("column_index %0d, expected %0d",
                                           rsp_data.column_index, want.column_index));
                if (rsp_data.row_count !== want.row_count)
                    report_error($sformatf("row_count %0d, expected %0d",
                                           rsp_data.row_count, want.row_count));
                if (rsp_data.success !== want.success)
                    report_error($sformatf("success %b, expected %b",
                                           rsp_data.success, want.success));
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        req_item_t it;
        it.req_type = REQ_BYTE;
        it.data_byte = b;
        text_feed.insert(text_feed.size(), it);
        items_queued++;
    endtask

    task automatic push_end();
        req_item_t it;
        it.req_type = REQ_END;
        it.data_byte = 8'($urandom_range(0, 255));
        text_feed.insert(text_feed.size(), it);
        items_queued++;
    endtask

    // Any byte that carries no meaning under the current setting.
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == delim_cfg || b == encl_cfg || b == CHAR_CR || b == CHAR_LF)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic gen_field();
        int shape;
        int n;
        shape = $urandom_range(0, 9);
        n = $urandom_range(0, 4);
        if (shape < 4)
            repeat (n) push_byte(plain_byte());
        else
        begin
            push_byte(encl_cfg);
            repeat (n)
            begin
                case ($urandom_range(0, 7))
                    0: push_byte(delim_cfg);
                    1: push_byte(CHAR_CR);
                    2: push_byte(CHAR_LF);
                    3:
                    begin
                        push_byte(encl_cfg);
                        push_byte(encl_cfg);
                    end
                    default: push_byte(plain_byte());
                endcase
            end
            push_byte(encl_cfg);
            // Text straight after a closing quote carries on the same field.
            if (shape == 9)
                push_byte(plain_byte());
        end
    endtask

    // One text: mostly well-formed records, sometimes noise or nothing at all.
    task automatic gen_text();
        int shape;
        int cols;
        int recs;
        int width;
        shape = $urandom_range(0, 19);
        if (shape == 0)
        begin
            repeat ($urandom_range(1, 30))
            begin
                case ($urandom_range(0, 5))
                    0: push_byte(delim_cfg);
                    1: push_byte(encl_cfg);
                    2: push_byte(CHAR_CR);
                    3: push_byte(CHAR_LF);
                    default: push_byte(8'($urandom_range(0, 255)));
                endcase
            end
        end
        else if (shape > 1)
        begin
            cols = $urandom_range(1, 5);
            recs = $urandom_range(1, 6);
            for (int r = 0; r < recs; r++)
            begin
                width = ($urandom_range(0, 11) == 0) ? int'($urandom_range(1, 6)) : cols;
                for (int f = 0; f < width; f++)
                begin
                    gen_field();
                    if (f < width - 1)
                        push_byte(delim_cfg);
                end
                if (r < recs - 1 || $urandom_range(0, 5) != 0)
                begin
                    case ($urandom_range(0, 9))
                        0: push_byte(CHAR_CR);
                        1:
                        begin
                            push_byte(CHAR_CR);
                            push_byte(CHAR_LF);
                        end
                        2:
                        begin
                            push_byte(CHAR_LF);
                            push_byte(CHAR_LF);
                        end
                        3:
                        begin
                            push_byte(CHAR_CR);
                            push_byte(CHAR_LF);
                            push_byte(CHAR_LF);
                        end
                        default: push_byte(CHAR_LF);
                    endcase
                end
            end
        end
        push_end();
    endtask

    task automatic fill_random(input int n);
        int start;
        start = items_queued;
        while (items_queued - start < n)
            gen_text();
    endtask

    // Waits until every queued item has gone in and every token has come out,
    // then lets the pipeline settle in case the last items gave no token.
    task automatic drain();
        while (text_feed.size() != 0 || req_valid || expected_tokens.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic program_reg(input logic idx, input logic [7:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'h0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[7:0] !== value)
            report_error($sformatf("register %0d reads %h, written %h",
                                   idx, prdata[7:0], value));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_DELIMITER)
            delim_cfg = value;
        else
            encl_cfg = value;
    endtask

    task automatic run_setting(input logic [7:0] delim, input logic [7:0] encl,
                               input bit wide);
        program_reg(REG_DELIMITER, delim);
        program_reg(REG_ENCLOSURE, encl);
        settings_used++;
        // Two records wider than the column limit, so both counts saturate and agree.
        if (wide)
        begin
            repeat (258) push_byte(delim_cfg);
            push_byte(CHAR_LF);
            repeat (257) push_byte(delim_cfg);
            push_byte(plain_byte());
            push_byte(CHAR_LF);
            push_end();
        end
        fill_random(PHASE_ITEMS);
        drain();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty text.
        push_end();
        // Extreme bytes in a two-field record, then a swallowed LF.
        push_byte(8'h00);
        push_byte(delim_cfg);
        push_byte(8'hFF);
        push_byte(CHAR_LF);
        push_byte(CHAR_LF);
        // Quoted field with a doubled enclosure, closed by a CR.
        push_byte("a");
        push_byte(delim_cfg);
        push_byte(encl_cfg);
        push_byte("x");
        push_byte(encl_cfg);
        push_byte(encl_cfg);
        push_byte("y");
        push_byte(encl_cfg);
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
        // Text after a closing quote in a short record, which gives the mismatch.
        push_byte(encl_cfg);
        push_byte("q");
        push_byte(encl_cfg);
        push_byte("z");
        push_byte(CHAR_LF);
        push_byte(8'hFF);
        push_end();
        // A final record with no newline is never counted.
        push_byte("b");
        push_byte(delim_cfg);
        push_byte("c");
        push_end();

        fill_random(PHASE_ITEMS);
        drain();

        run_setting(8'd0, 8'd255, 1'b1);
        run_setting(8'd255, 8'd0, 1'b0);
        run_setting(8'd9, 8'd39, 1'b0);
        run_setting(CHAR_CR, CHAR_LF, 1'b0);
        run_setting(8'd59, 8'd59, 1'b0);
        run_setting(DELIMITER_RESET, ENCLOSURE_RESET, 1'b0);

        $display("Checked %0d tokens from %0d input transfers over %0d texts and %0d settings.",
                 tokens_checked, items_fed, texts_done, settings_used);
        $display("Column mismatches reported: %0d.", mismatches_seen);
        if (errors == 0)
            $display("csv_field_tokenizer_tb: PASS");
        else
            $display("csv_field_tokenizer_tb: FAIL");
        $finish;
    end

    initial
    begin
        #1_500_000;
        $display("csv_field_tokenizer_tb: FAIL");
        $finish;
    end

endmodule
